[rtl/stq_pkg.sv]
// Shared types and constants for the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;
   localparam int CAPACITY    = 64;
   localparam int TIME_BITS   = 32;
   localparam int MAX_RESULTS = 64;
   localparam int SLOT_BITS   = $clog2(CAPACITY);
   localparam int LINK_BITS   = SLOT_BITS + 1;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
   localparam logic [LINK_BITS-1:0] NONE_LINK = LINK_BITS'(CAPACITY);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_ADJUST = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_DONE    = 3'd0,
      STAT_EXPIRED = 3'd1,
      STAT_NONE    = 3'd2,
      STAT_ACTIVE  = 3'd3,
      STAT_INACT   = 3'd4
   } stat_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  timer_id;
      logic [31:0] expire_time;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] slot_out;
      logic       last;
   } rsp_type;

   typedef struct packed {
      op_type                 op;
      logic                   in_range;
      logic [SLOT_BITS-1:0]   slot;
      logic [TIME_BITS-1:0]   exp_t;
      logic [TIME_BITS-1:0]   now_t;
   } cmd_type;
endpackage

[rtl/stq_front.sv]
// Front end: accepts request words, decodes them and queues up to two commands.
`timescale 1ns / 1ps
module stq_front import stq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_pop,
   output cmd_type cmd
);
   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       push;

   always_comb begin
      dec.op       = op_type'(req_data.opcode);
      dec.in_range = (32'(req_data.timer_id) < CAPACITY);
      dec.slot     = SLOT_BITS'(req_data.timer_id);
      dec.exp_t    = req_data.expire_time[TIME_BITS-1:0];
      dec.now_t    = req_data.now_time[TIME_BITS-1:0];
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= dec;
   end
endmodule

[rtl/stq_back.sv]
// Back end: list sequencer with link and expiry memories and the result register.
`timescale 1ns / 1ps
module stq_back import stq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   typedef enum logic [11:0] {
      S_IDLE      = 12'b000000000001,
      S_TICK_RD   = 12'b000000000010,
      S_TICK_CMP  = 12'b000000000100,
      S_TICK_END  = 12'b000000001000,
      S_UNL_RD    = 12'b000000010000,
      S_UNL_WR    = 12'b000000100000,
      S_WALK_INIT = 12'b000001000000,
      S_WALK_RD   = 12'b000010000000,
      S_WALK_CMP  = 12'b000100000000,
      S_LINK_A    = 12'b001000000000,
      S_LINK_B    = 12'b010000000000,
      S_EMIT      = 12'b100000000000
   } state_type;

   logic [TIME_BITS-1:0] exp_mem  [CAPACITY];
   logic [LINK_BITS-1:0] next_mem [CAPACITY];
   logic [LINK_BITS-1:0] prev_mem [CAPACITY];

   state_type            state_ff, state_in;
   logic [LINK_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CAPACITY-1:0]  active_ff, active_in;
   logic [SLOT_BITS-1:0] s_ff, s_in, pend_s_ff, pend_s_in;
   logic [TIME_BITS-1:0] e_ff, e_in, now_ff, now_in;
   op_type               op_ff, op_in;
   logic [LINK_BITS-1:0] cur_ff, cur_in, p_ff, p_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 pend_v_ff, pend_v_in;
   stat_type             st_ff, st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 rd_en;
   logic [SLOT_BITS-1:0] rd_addr;
   logic [TIME_BITS-1:0] exp_q;
   logic [LINK_BITS-1:0] next_q, prev_q;
   logic                 exp_we, next_we, prev_we;
   logic [SLOT_BITS-1:0] exp_wa, next_wa, prev_wa;
   logic [TIME_BITS-1:0] exp_wd;
   logic [LINK_BITS-1:0] next_wd, prev_wd;
   logic                 out_free, load;
   rsp_type              out_word;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      active_in = active_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      now_in    = now_ff;
      op_in     = op_ff;
      cur_in    = cur_ff;
      p_in      = p_ff;
      cnt_in    = cnt_ff;
      pend_v_in = pend_v_ff;
      pend_s_in = pend_s_ff;
      st_in     = st_ff;
      cmd_pop   = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = s_ff;
      exp_we    = 1'b0;
      exp_wa    = s_ff;
      exp_wd    = e_ff;
      next_we   = 1'b0;
      next_wa   = s_ff;
      next_wd   = NONE_LINK;
      prev_we   = 1'b0;
      prev_wa   = s_ff;
      prev_wd   = NONE_LINK;
      load      = 1'b0;
      out_word  = '{status: 3'(STAT_DONE), slot_out: 6'(s_ff), last: 1'b1};
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               s_in    = cmd.slot;
               e_in    = cmd.exp_t;
               now_in  = cmd.now_t;
               op_in   = cmd.op;
               unique case (cmd.op)
                  OP_TICK: begin
                     cnt_in    = '0;
                     pend_v_in = 1'b0;
                     state_in  = S_TICK_RD;
                  end
                  OP_ADD: begin
                     if (!cmd.in_range) begin
                        st_in    = STAT_INACT;
                        state_in = S_EMIT;
                     end else if (active_ff[cmd.slot]) begin
                        st_in    = STAT_ACTIVE;
                        state_in = S_EMIT;
                     end else begin
                        exp_we               = 1'b1;
                        exp_wa               = cmd.slot;
                        exp_wd               = cmd.exp_t;
                        active_in[cmd.slot]  = 1'b1;
                        cur_in               = head_ff;
                        state_in             = S_WALK_RD;
                     end
                  end
                  default: begin
                     if (!(cmd.in_range && active_ff[cmd.slot])) begin
                        st_in    = STAT_INACT;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_UNL_RD;
                     end
                  end
               endcase
            end
         end
         S_TICK_RD: begin
            if (head_ff == NONE_LINK || 32'(cnt_ff) == MAX_RESULTS) begin
               state_in = S_TICK_END;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff[SLOT_BITS-1:0];
               state_in = S_TICK_CMP;
            end
         end
         S_TICK_CMP: begin
            if (exp_q > now_ff) begin
               state_in = S_TICK_END;
            end else if (!pend_v_ff || out_free) begin
               // hand the previous pop out, it is known not to be the final one
               if (pend_v_ff) begin
                  load     = 1'b1;
                  out_word = '{status: 3'(STAT_EXPIRED), slot_out: 6'(pend_s_ff), last: 1'b0};
               end
               head_in = next_q;
               if (next_q != NONE_LINK) begin
                  prev_we = 1'b1;
                  prev_wa = next_q[SLOT_BITS-1:0];
                  prev_wd = NONE_LINK;
               end else begin
                  tail_in = NONE_LINK;
               end
               active_in[head_ff[SLOT_BITS-1:0]] = 1'b0;
               pend_v_in = 1'b1;
               pend_s_in = head_ff[SLOT_BITS-1:0];
               cnt_in    = cnt_ff + 1'b1;
               state_in  = S_TICK_RD;
            end
         end
         S_TICK_END: begin
            if (out_free) begin
               load = 1'b1;
               if (pend_v_ff)
                  out_word = '{status: 3'(STAT_EXPIRED), slot_out: 6'(pend_s_ff), last: 1'b1};
               else
                  out_word = '{status: 3'(STAT_NONE), slot_out: 6'd0, last: 1'b1};
               state_in = S_IDLE;
            end
         end
         S_UNL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = s_ff;
            state_in = S_UNL_WR;
         end
         S_UNL_WR: begin
            if (prev_q != NONE_LINK) begin
               next_we = 1'b1;
               next_wa = prev_q[SLOT_BITS-1:0];
               next_wd = next_q;
            end else begin
               head_in = next_q;
            end
            if (next_q != NONE_LINK) begin
               prev_we = 1'b1;
               prev_wa = next_q[SLOT_BITS-1:0];
               prev_wd = prev_q;
            end else begin
               tail_in = prev_q;
            end
            if (op_ff == OP_ADJUST) begin
               exp_we   = 1'b1;
               state_in = S_WALK_INIT;
            end else begin
               active_in[s_ff] = 1'b0;
               st_in           = STAT_DONE;
               state_in        = S_EMIT;
            end
         end
         S_WALK_INIT: begin
            cur_in   = head_ff;
            state_in = S_WALK_RD;
         end
         S_WALK_RD: begin
            if (cur_ff == NONE_LINK) begin
               p_in     = tail_ff;
               state_in = S_LINK_A;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cur_ff[SLOT_BITS-1:0];
               state_in = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            // equal expiry goes behind, so walk past it
            if (exp_q <= e_ff) begin
               cur_in   = next_q;
               state_in = S_WALK_RD;
            end else begin
               p_in     = prev_q;
               state_in = S_LINK_A;
            end
         end
         S_LINK_A: begin
            next_we  = 1'b1;
            next_wa  = s_ff;
            next_wd  = cur_ff;
            prev_we  = 1'b1;
            prev_wa  = s_ff;
            prev_wd  = p_ff;
            state_in = S_LINK_B;
         end
         S_LINK_B: begin
            if (cur_ff != NONE_LINK) begin
               prev_we = 1'b1;
               prev_wa = cur_ff[SLOT_BITS-1:0];
               prev_wd = LINK_BITS'(s_ff);
            end else begin
               tail_in = LINK_BITS'(s_ff);
            end
            if (p_ff != NONE_LINK) begin
               next_we = 1'b1;
               next_wa = p_ff[SLOT_BITS-1:0];
               next_wd = LINK_BITS'(s_ff);
            end else begin
               head_in = LINK_BITS'(s_ff);
            end
            st_in    = STAT_DONE;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               out_word = '{status: 3'(st_ff), slot_out: 6'(s_ff), last: 1'b1};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_word;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NONE_LINK;
         tail_ff      <= NONE_LINK;
         active_ff    <= '0;
         pend_v_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         active_ff    <= active_in;
         pend_v_ff    <= pend_v_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      e_ff      <= e_in;
      now_ff    <= now_in;
      op_ff     <= op_in;
      cur_ff    <= cur_in;
      p_ff      <= p_in;
      pend_s_ff <= pend_s_in;
      st_ff     <= st_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (exp_we)  exp_mem[exp_wa]   <= exp_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         exp_q  <= exp_mem[rd_addr];
         next_q <= next_mem[rd_addr];
         prev_q <= prev_mem[rd_addr];
      end
   end
endmodule

[rtl/sorted_timer_queue_top.sv]
// Sorted timer queue top level: request queue front end and list sequencer.
// An add walks the list from the head past timers expiring no later; adjust unlinks the timer first.
// Delete unlinks the timer; a tick pops expired timers from the head, one result word per timer.
// The sequencer handles one command at a time, with one read port shared by the link and expiry memories.
// Reset is synchronous, active high: the list empties and all timers go inactive.
`timescale 1ns / 1ps
module sorted_timer_queue_top import stq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   stq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   stq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

[rtl/stq_checker.sv]
// Port-level checks for the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps
module stq_checker import stq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != 3'(STAT_EXPIRED) |-> rsp_data.last)
      else $error("single result word without last");

   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == 3'(STAT_NONE) |-> rsp_data.slot_out == 6'd0)
      else $error("empty tick carries a slot");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= 3'(STAT_INACT))
      else $error("bad status code");
endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
